// ===== hw/rtl/bvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bvs_pkg;

	localparam int MAX_LEN   = 64;
	localparam int BYTE_W    = 8;
	localparam int IDX_W     = $clog2(MAX_LEN);
	localparam int CNT_W     = IDX_W + 1;
	// one remainder step per dividend bit, with a leading bit for 256
	localparam int DIV_STEPS = BYTE_W + 1;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_RAND = 1'b1;

	typedef struct packed {
		logic load;      // store element at the fill count
		logic arm;       // set the swap position from the fill count
		logic div_start; // latch random byte, start remainder unit
		logic rd_i;      // read element at swap position
		logic rd_j;      // read element at partner, hold element i
		logic wr_i;      // element i takes element j
		logic wr_j;      // element j takes held element i, step down
		logic em_rd;     // read element for emission
		logic em_ld;     // move element into the output register
	} bvs_cmd_t;

	typedef struct packed {
		logic single;    // vector has one element once this load lands
		logic div_done;
		logic reject;
		logic pos_is_1;
		logic out_free;
		logic em_last;
	} bvs_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bvs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bvs_in_if;
	import bvs_pkg::*;
	logic              valid;
	logic              ready;
	logic              mode;
	logic [BYTE_W-1:0] value;
	logic              last;

	modport source (output valid, output mode, output value, output last, input ready);
	modport sink (input valid, input mode, input value, input last, output ready);
endinterface

interface bvs_out_if;
	import bvs_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_value;
	logic              out_last;

	modport source (output valid, output out_value, output out_last, input ready);
	modport sink (input valid, input out_value, input out_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bvs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bvs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bvs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bvs_ctrl import bvs_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      mode,
	input  wire logic      last,
	input  wire bvs_stat_t stat,
	output logic           in_ready,
	output bvs_cmd_t       cmd
);

	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_SHUF  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_RD_I  = 4'd3;
	localparam logic [3:0] S_RD_J  = 4'd4;
	localparam logic [3:0] S_WR_I  = 4'd5;
	localparam logic [3:0] S_WR_J  = 4'd6;
	localparam logic [3:0] S_EM_RD = 4'd7;
	localparam logic [3:0] S_EM_LD = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       take;

	assign in_ready = (state_q == S_LOAD) || (state_q == S_SHUF);
	assign take     = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_LOAD: begin
				if (take && mode == MODE_LOAD) begin
					cmd.load = 1'b1;
					if (last) begin
						if (stat.single) begin
							state_d = S_EM_RD;
						end else begin
							cmd.arm = 1'b1;
							state_d = S_SHUF;
						end
					end
				end
			end
			S_SHUF: begin
				if (take && mode == MODE_RAND) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = stat.reject ? S_SHUF : S_RD_I;
				end
			end
			S_RD_I: begin
				cmd.rd_i = 1'b1;
				state_d  = S_RD_J;
			end
			S_RD_J: begin
				cmd.rd_j = 1'b1;
				state_d  = S_WR_I;
			end
			S_WR_I: begin
				cmd.wr_i = 1'b1;
				state_d  = S_WR_J;
			end
			S_WR_J: begin
				cmd.wr_j = 1'b1;
				state_d  = stat.pos_is_1 ? S_EM_RD : S_SHUF;
			end
			S_EM_RD: begin
				cmd.em_rd = 1'b1;
				state_d   = S_EM_LD;
			end
			S_EM_LD: begin
				// hold the read address until the output register frees up
				cmd.em_rd = 1'b1;
				if (stat.out_free) begin
					cmd.em_ld = 1'b1;
					state_d   = stat.em_last ? S_LOAD : S_EM_RD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bvs_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bvs_dp import bvs_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bvs_cmd_t          cmd,
	input  wire logic [BYTE_W-1:0] value,
	output bvs_stat_t              stat,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [BYTE_W-1:0] out_value,
	output logic                   out_last
);

	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  pos_q;
	logic [IDX_W-1:0]  k_q;
	logic [STEP_W-1:0] step_q;
	logic [BYTE_W-1:0] val_q;
	logic [BYTE_W:0]   sh_q;
	logic [CNT_W-1:0]  ra_q;
	logic [CNT_W-1:0]  rb_q;
	logic [BYTE_W-1:0] tmp_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_value_q;
	logic              out_last_q;

	logic              full;
	logic [IDX_W-1:0]  pos_arm;
	logic [CNT_W-1:0]  m;
	logic [CNT_W:0]    ta;
	logic [CNT_W:0]    tb;
	logic [CNT_W-1:0]  ra_n;
	logic [CNT_W-1:0]  rb_n;
	logic [BYTE_W:0]   rej_sum;
	logic [IDX_W-1:0]  j;
	logic              em_last;
	logic              out_free;

	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [BYTE_W-1:0] wdata;
	logic [IDX_W-1:0]  raddr;
	logic [BYTE_W-1:0] rdata;

	assign full    = (count_q == CNT_W'(MAX_LEN));
	assign pos_arm = full ? IDX_W'(MAX_LEN - 1) : count_q[IDX_W-1:0];
	assign m       = {1'b0, pos_q} + CNT_W'(1);

	// parallel restoring remainder steps: random byte mod m, and 256 mod m
	assign ta   = {ra_q, sh_q[BYTE_W]};
	assign tb   = {rb_q, (step_q == '0)};
	assign ra_n = (ta >= {1'b0, m}) ? CNT_W'(ta - {1'b0, m}) : ta[CNT_W-1:0];
	assign rb_n = (tb >= {1'b0, m}) ? CNT_W'(tb - {1'b0, m}) : tb[CNT_W-1:0];

	// reject when r >= 256 - (256 mod m)
	assign rej_sum = {1'b0, val_q} + (BYTE_W + 1)'(rb_q);
	assign j       = ra_q[IDX_W-1:0];

	assign em_last  = ({1'b0, k_q} == count_q - CNT_W'(1));
	assign out_free = !out_valid_q || out_ready;

	assign stat.single   = (count_q == '0);
	assign stat.div_done = (step_q == STEP_W'(DIV_STEPS));
	assign stat.reject   = rej_sum[BYTE_W];
	assign stat.pos_is_1 = (pos_q == IDX_W'(1));
	assign stat.out_free = out_free;
	assign stat.em_last  = em_last;

	always_comb begin
		we    = (cmd.load && !full) || cmd.wr_i || cmd.wr_j;
		waddr = j;
		wdata = tmp_q;
		if (cmd.load) begin
			waddr = count_q[IDX_W-1:0];
			wdata = value;
		end else if (cmd.wr_i) begin
			waddr = pos_q;
			wdata = rdata;
		end
	end

	always_comb begin
		priority if (cmd.rd_j) begin
			raddr = j;
		end else if (cmd.em_rd) begin
			raddr = k_q;
		end else begin
			raddr = pos_q;
		end
	end

	bvs_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_LEN)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pos_q       <= '0;
			k_q         <= '0;
			step_q      <= STEP_W'(DIV_STEPS);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.arm) begin
				pos_q <= pos_arm;
			end else if (cmd.wr_j) begin
				pos_q <= pos_q - IDX_W'(1);
			end
			if (cmd.div_start) begin
				step_q <= '0;
			end else if (!stat.div_done) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cmd.em_ld) begin
				if (em_last) begin
					count_q <= '0;
					k_q     <= '0;
				end else begin
					k_q <= k_q + IDX_W'(1);
				end
			end
			if (cmd.em_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			val_q <= value;
			sh_q  <= {1'b0, value};
			ra_q  <= '0;
			rb_q  <= '0;
		end else if (!stat.div_done) begin
			sh_q <= {sh_q[BYTE_W-1:0], 1'b0};
			ra_q <= ra_n;
			rb_q <= rb_n;
		end
		if (cmd.rd_j) begin
			tmp_q <= rdata;
		end
		if (cmd.em_ld) begin
			out_value_q <= rdata;
			out_last_q  <= em_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/byte_vector_shuffle.sv =====
// Byte vector shuffle: loads a vector of up to 64 bytes, then shuffles it in
// place with one random byte per step and emits it in stored order.
// Input channel din: mode 0 carries an element, last closes the vector;
// mode 1 carries a random byte. Elements that arrive while shuffling and
// random bytes that arrive while loading are taken and dropped.
// A random byte first passes the bit-serial remainder unit (byte mod (i+1)
// and 256 mod (i+1) in parallel), then the swap through the element RAM's
// one read port: read i, read j, write i, write j.
// A rejected byte returns after the remainder unit alone.
// After the last swap, or on a one-element vector, the elements leave on
// dout one at a time, read from the RAM, then loaded into the output register;
// din is not ready until the final word is in the output register, which
// lets din go on while it waits; a stalled dout holds the emission in place.
// Reset empties the vector and returns to loading; the RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module byte_vector_shuffle import bvs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	bvs_in_if.sink   din,
	bvs_out_if.source dout
);

	bvs_cmd_t  cmd;
	bvs_stat_t stat;

	bvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.mode     (din.mode),
		.last     (din.last),
		.stat     (stat),
		.in_ready (din.ready),
		.cmd      (cmd)
	);

	bvs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (din.value),
		.stat      (stat),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.out_value (dout.out_value),
		.out_last  (dout.out_last)
	);

endmodule

`default_nettype wire
